// File: hdl/ucwf_pkg.sv
package ucwf_pkg;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
  } out_t;

  // Classified byte as held in the queue and the pending window
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] seq_len;  // 1 to 4, 0 for a byte that cannot lead
    logic       cont;     // byte has the form 10xxxxxx
  } entry_t;

  localparam logic [15:0] MaxBytesReset = 16'd4096;
  localparam int unsigned CpWidth       = 21;

  // Sequence length announced by a lead byte
  function automatic logic [2:0] seq_length(logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Codepoint whitelist
  function automatic logic allowed_cp(logic [CpWidth-1:0] cp);
    logic ok;
    ok = (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D)
      || (cp >= 21'h20 && cp <= 21'h7E)
      || (cp >= 21'h0400 && cp <= 21'h052F)
      || (cp >= 21'h2600 && cp <= 21'h27BF)
      || (cp >= 21'h1F300 && cp <= 21'h1F64F)
      || (cp >= 21'h1F680 && cp <= 21'h1F6FF);
    return ok;
  endfunction

endpackage

// File: hdl/ucwf_front.sv
module ucwf_front import ucwf_pkg::*; (
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  in_t    in_data_i,
  input  logic   full_i,
  output logic   push_o,
  output entry_t entry_o
);

  // Accept while the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the byte on its way into the queue
  always_comb begin
    entry_o.data    = in_data_i.in_byte;
    entry_o.last    = in_data_i.in_last;
    entry_o.seq_len = seq_length(in_data_i.in_byte);
    entry_o.cont    = (in_data_i.in_byte[7:6] == 2'b10);
  end

endmodule

// File: hdl/ucwf_fifo.sv
module ucwf_fifo import ucwf_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: hdl/ucwf_back.sv
module ucwf_back import ucwf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fifo_valid_i,
  input  entry_t      fifo_entry_i,
  output logic        fifo_pop_o,
  input  logic [15:0] max_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_EMIT  = 5'b00100,
    S_END   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e       state_q, state_d;
  entry_t       pend_q [4];
  entry_t       pend_d [4];
  logic [2:0]   count_q, count_d;
  logic [2:0]   rem_q, rem_d;
  logic         last_q, last_d;
  logic [15:0]  emitted_q, emitted_d;
  out_t         hold_q, hold_d;
  logic         hold_valid_q, hold_valid_d;
  out_t         out_q, out_d;
  logic         out_valid_q, out_valid_d;

  logic               can_push, blocked;
  logic [CpWidth-1:0] cp;
  logic               cont_ok;
  logic [2:0]         head_len;

  assign head_len = pend_q[0].seq_len;
  assign can_push = !out_valid_q || out_ready_i;
  assign blocked  = hold_valid_q && !can_push;

  // Decode the codepoint of the sequence at the head of the window
  always_comb begin
    unique case (head_len)
      3'd1:    cp = {14'd0, pend_q[0].data[6:0]};
      3'd2:    cp = {10'd0, pend_q[0].data[4:0], pend_q[1].data[5:0]};
      3'd3:    cp = {5'd0, pend_q[0].data[3:0], pend_q[1].data[5:0],
                     pend_q[2].data[5:0]};
      3'd4:    cp = {pend_q[0].data[2:0], pend_q[1].data[5:0],
                     pend_q[2].data[5:0], pend_q[3].data[5:0]};
      default: cp = '0;
    endcase
    cont_ok = (head_len < 3'd2 || pend_q[1].cont)
           && (head_len < 3'd3 || pend_q[2].cont)
           && (head_len < 3'd4 || pend_q[3].cont);
  end

  // Sequencer: one window action per cycle, unless a result it must pass is held by a stalled output
  always_comb begin
    logic       pop;
    logic       prod;
    out_t       prod_data;
    logic [2:0] shift_n;
    logic [2:0] src;

    state_d      = state_q;
    pend_d       = pend_q;
    count_d      = count_q;
    rem_d        = rem_q;
    last_d       = last_q;
    emitted_d    = emitted_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pop          = 1'b0;
    prod         = 1'b0;
    prod_data    = '0;
    shift_n      = 3'd0;
    src          = 3'd0;

    unique case (state_q)
      S_IDLE: begin
        // Take the next byte into the window
        if (fifo_valid_i) begin
          pop                    = 1'b1;
          pend_d[count_q[1:0]]   = fifo_entry_i;
          count_d                = count_q + 3'd1;
          last_d                 = fifo_entry_i.last;
          state_d                = S_SCAN;
        end
      end
      S_SCAN: begin
        if (count_q == 3'd0 || (head_len != 3'd0 && count_q < head_len)) begin
          state_d = last_q ? S_END : S_FLUSH;
        end else if (head_len == 3'd0 || !cont_ok) begin
          // Drop a bad lead and rescan
          shift_n = 3'd1;
        end else if (allowed_cp(cp)) begin
          rem_d   = head_len;
          state_d = S_EMIT;
        end else begin
          shift_n = head_len;
        end
      end
      S_EMIT: begin
        // Pass one byte of the sequence, subject to the byte limit
        if (emitted_q < max_bytes_i) begin
          if (!blocked) begin
            prod                 = 1'b1;
            prod_data.out_byte   = pend_q[0].data;
            prod_data.byte_valid = 1'b1;
            emitted_d            = emitted_q + 16'd1;
            shift_n              = 3'd1;
            rem_d                = rem_q - 3'd1;
          end
        end else begin
          shift_n = 3'd1;
          rem_d   = rem_q - 3'd1;
        end
        if (shift_n != 3'd0 && rem_q == 3'd1) begin
          state_d = S_SCAN;
        end
      end
      S_END: begin
        // Close the stream: end marker, clear window and byte count
        if (!blocked) begin
          prod                 = 1'b1;
          prod_data.stream_end = 1'b1;
          count_d              = 3'd0;
          emitted_d            = 16'd0;
          state_d              = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // Release the final result of this byte
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          out_d          = hold_q;
          out_d.run_last = 1'b1;
          out_valid_d    = 1'b1;
          hold_valid_d   = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Move the held result out and hold the new one
    if (prod) begin
      if (hold_valid_q) begin
        out_d          = hold_q;
        out_d.run_last = 1'b0;
        out_valid_d    = 1'b1;
      end
      hold_d       = prod_data;
      hold_valid_d = 1'b1;
    end

    // Shift the window down
    if (shift_n != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        src = 3'(i) + shift_n;
        if (src < 3'd4) begin
          pend_d[i] = pend_q[src[1:0]];
        end
      end
      count_d = count_q - shift_n;
    end

    fifo_pop_o = pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= 3'd0;
      rem_q        <= 3'd0;
      last_q       <= 1'b0;
      emitted_q    <= 16'd0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rem_q        <= rem_d;
      last_q       <= last_d;
      emitted_q    <= emitted_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/utf8_codepoint_whitelist_filter_top.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------
// input    | in_valid_i / in_ready_o | in_data_i  : in_byte, in_last
// output   | out_valid_o/out_ready_i | out_data_o : out_byte, byte_valid,
//          |                         |              run_last, stream_end
// config   | cfg_valid_i/cfg_ready_o | cfg_data_i : max_output_bytes
//
// Bytes enter a FifoDepth-entry queue at one per cycle while it has room.
// The back sequencer loads a byte into its window, then drops, rejects or accepts
// each lead, passes or discards each byte, emits the end marker and releases the
// final result.
// Reset empties the queue and window and sets the byte limit to 4096.
// A stalled output holds the sequencer when it must pass a result; the queue keeps taking input while it has room.
module utf8_codepoint_whitelist_filter_top import ucwf_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic        push, full, fifo_valid, fifo_pop;
  entry_t      push_entry, head_entry;
  logic [15:0] max_bytes_q;

  // Hold the byte limit
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesReset;
    end else if (cfg_valid_i) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  ucwf_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  ucwf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .entry_o (head_entry)
  );

  ucwf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_entry_i (head_entry),
    .fifo_pop_o   (fifo_pop),
    .max_bytes_i  (max_bytes_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: tb/tb_utf8_codepoint_whitelist_filter_top.sv
`timescale 1ns / 1ps

module tb_utf8_codepoint_whitelist_filter_top;
  import ucwf_pkg::*;

  localparam int unsigned RandomBytes = 380;
  localparam int unsigned PhaseBytes  = 60;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned MaxReported = 10;

  // Predict the filtered byte stream and check the block's output against it
  class utf8_filter_scoreboard;
    logic [7:0]  held [4];
    int unsigned held_count;
    logic [15:0] byte_limit;
    logic [15:0] passed_count;
    out_t        expected_q [$];
    int unsigned mismatches;

    function new();
      foreach (held[i]) held[i] = '0;
      held_count   = 0;
      byte_limit   = MaxBytesReset;
      passed_count = 0;
      mismatches   = 0;
    endfunction

    function void set_limit(logic [15:0] value);
      byte_limit = value;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // Sequence length announced by a lead byte, 0 when it cannot lead
    function int unsigned lead_length(logic [7:0] b);
      casez (b)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 0;
      endcase
    endfunction

    function bit whitelisted(logic [20:0] cp);
      return (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D)
          || (cp >= 21'h20 && cp <= 21'h7E)
          || (cp >= 21'h0400 && cp <= 21'h052F)
          || (cp >= 21'h2600 && cp <= 21'h27BF)
          || (cp >= 21'h1F300 && cp <= 21'h1F64F)
          || (cp >= 21'h1F680 && cp <= 21'h1F6FF);
    endfunction

    // Drop the oldest n held bytes
    function void drop_front(int unsigned n);
      if (n >= held_count) begin
        held_count = 0;
      end else begin
        for (int unsigned i = 0; i + n < held_count; i++) held[i] = held[i + n];
        held_count = held_count - n;
      end
    endfunction

    // Work out every result caused by one accepted input transaction
    function void accept_byte(in_t item);
      out_t        batch [$];
      out_t        res;
      logic [20:0] cp;
      int unsigned len;
      bit          ok;
      held[held_count] = item.in_byte;
      held_count++;
      while (held_count > 0) begin
        len = lead_length(held[0]);
        if (len == 0) begin
          drop_front(1);
          continue;
        end
        if (held_count < len) break;
        case (len)
          1:       cp = {14'd0, held[0][6:0]};
          2:       cp = {16'd0, held[0][4:0]};
          3:       cp = {17'd0, held[0][3:0]};
          default: cp = {18'd0, held[0][2:0]};
        endcase
        ok = 1'b1;
        for (int unsigned j = 1; j < len; j++) begin
          if (held[j][7:6] != 2'b10) ok = 1'b0;
          cp = {cp[14:0], held[j][5:0]};
        end
        // a broken continuation costs only the lead; rescan the rest
        if (!ok) begin
          drop_front(1);
          continue;
        end
        if (whitelisted(cp)) begin
          for (int unsigned j = 0; j < len; j++) begin
            if (passed_count < byte_limit) begin
              res            = '0;
              res.out_byte   = held[j];
              res.byte_valid = 1'b1;
              batch.push_back(res);
              passed_count++;
            end
          end
        end
        drop_front(len);
      end
      // end of stream: discard any unfinished sequence, emit the marker
      if (item.in_last) begin
        held_count     = 0;
        passed_count   = 0;
        res            = '0;
        res.stream_end = 1'b1;
        batch.push_back(res);
      end
      if (batch.size() > 0) begin
        res          = batch.pop_back();
        res.run_last = 1'b1;
        batch.push_back(res);
      end
      foreach (batch[i]) expected_q.push_back(batch[i]);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: unexpected result: byte %02h valid %0b last %0b end %0b", $time,
                   got.out_byte, got.byte_valid, got.run_last, got.stream_end);
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid
            || got.run_last !== want.run_last || got.stream_end !== want.stream_end) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display({"%0t: mismatch: expected byte %02h valid %0b last %0b end %0b,",
                      " got byte %02h valid %0b last %0b end %0b"},
                     $time, want.out_byte, want.byte_valid, want.run_last, want.stream_end,
                     got.out_byte, got.byte_valid, got.run_last, got.stream_end);
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  utf8_filter_scoreboard sb;
  logic [7:0]  stream_q [$];
  logic [7:0]  seq_q [$];
  bit          in_gaps    = 1'b0;
  bit          out_stalls = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  utf8_codepoint_whitelist_filter_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Stall the output side at random
  always @(negedge clk) begin
    if (!out_stalls) begin
      out_ready  <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(3, 0) == 0) stall_left = pick_gap(1'b1);
    end
  end

  // Sample handshakes; end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.accept_byte(in_data);
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int unsigned natural_length(logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Encode a codepoint into seq_q with the given number of bytes
  function automatic void encode_cp(logic [20:0] cp, int unsigned len);
    seq_q.delete();
    case (len)
      1: seq_q.push_back({1'b0, cp[6:0]});
      2: begin
        seq_q.push_back({3'b110, cp[10:6]});
        seq_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq_q.push_back({4'b1110, cp[15:12]});
        seq_q.push_back({2'b10, cp[11:6]});
        seq_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_q.push_back({5'b11110, cp[20:18]});
        seq_q.push_back({2'b10, cp[17:12]});
        seq_q.push_back({2'b10, cp[11:6]});
        seq_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Codepoints just inside and just outside the whitelist ranges
  function automatic logic [20:0] boundary_cp();
    case ($urandom_range(19, 0))
      0:       return 21'h08;
      1:       return 21'h0B;
      2:       return 21'h0C;
      3:       return 21'h1F;
      4:       return 21'h7F;
      5:       return 21'h3FF;
      6:       return 21'h400;
      7:       return 21'h52F;
      8:       return 21'h530;
      9:       return 21'h25FF;
      10:      return 21'h2600;
      11:      return 21'h27BF;
      12:      return 21'h27C0;
      13:      return 21'h1F2FF;
      14:      return 21'h1F300;
      15:      return 21'h1F64F;
      16:      return 21'h1F650;
      17:      return 21'h1F67F;
      18:      return 21'h1F680;
      default: return 21'h1F700;
    endcase
  endfunction

  function automatic logic [20:0] pick_cp();
    case ($urandom_range(9, 0))
      0, 1: return 21'($urandom_range(32'h7E, 32'h20));
      2: begin
        case ($urandom_range(2, 0))
          0:       return 21'h09;
          1:       return 21'h0A;
          default: return 21'h0D;
        endcase
      end
      3: return 21'($urandom_range(32'h52F, 32'h400));
      4: return 21'($urandom_range(32'h27BF, 32'h2600));
      5: return 21'($urandom_range(32'h1F64F, 32'h1F300));
      6: return 21'($urandom_range(32'h1F6FF, 32'h1F680));
      7: return boundary_cp();
      8: return 21'($urandom_range(32'h1FFFFF, 0));
      default: return 21'($urandom_range(32'h7F, 0));
    endcase
  endfunction

  // Well-formed sequence, now and then in overlong form
  function automatic void make_char();
    logic [20:0] cp;
    int unsigned len;
    cp  = pick_cp();
    len = natural_length(cp);
    if (len < 4 && $urandom_range(9, 0) == 0) len = $urandom_range(4, len + 1);
    encode_cp(cp, len);
  endfunction

  // Sequence cut short or with a continuation byte spoilt
  function automatic void make_broken();
    int unsigned idx;
    logic [7:0]  bad;
    do make_char(); while (seq_q.size() < 2);
    if ($urandom_range(1, 0) == 0) begin
      repeat ($urandom_range(seq_q.size() - 1, 1)) seq_q.delete(seq_q.size() - 1);
    end else begin
      idx = $urandom_range(seq_q.size() - 1, 1);
      do bad = 8'($urandom_range(255, 0)); while (bad[7:6] == 2'b10);
      seq_q[idx] = bad;
    end
  endfunction

  function automatic void make_noise();
    seq_q.delete();
    case ($urandom_range(2, 0))
      0:       seq_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
      1:       seq_q.push_back(8'($urandom_range(8'hFF, 8'hF8)));
      default: seq_q.push_back(8'($urandom_range(8'hFF, 8'h00)));
    endcase
  endfunction

  // Build one stream: mostly good characters, some broken ones and noise
  function automatic void build_stream();
    int unsigned target;
    int unsigned r;
    stream_q.delete();
    target = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
    while (stream_q.size() < target) begin
      r = $urandom_range(99, 0);
      if (r < 70) make_char();
      else if (r < 85) make_broken();
      else make_noise();
      foreach (seq_q[i]) stream_q.push_back(seq_q[i]);
    end
    // leave a sequence unfinished at the end of some streams
    if ($urandom_range(4, 0) == 0) begin
      make_broken();
      foreach (seq_q[i]) stream_q.push_back(seq_q[i]);
    end
  endfunction

  function automatic logic [15:0] phase_limit(int unsigned phase);
    case (phase)
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3:       return 16'd5;
      4:       return MaxBytesReset;
      5:       return 16'd3;
      default: return ($urandom_range(3, 0) == 0) ? 16'($urandom_range(16'hFFFF, 0))
                                                  : 16'($urandom_range(24, 0));
    endcase
  endfunction

  // Offer one byte; entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = pick_gap(in_gaps);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Hold input idle until every expected result is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned random_bytes;
    int unsigned phase_bytes;
    int unsigned phase;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: control and printable ASCII, rejected ASCII, each sequence length,
    // bad leads, a broken continuation and an unfinished sequence at stream end
    stream_q = '{8'h41, 8'h09, 8'h0A, 8'h0D, 8'h7E, 8'h7F, 8'h00,
                 8'hD0, 8'h96, 8'hE2, 8'h98, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80,
                 8'h80, 8'hFF, 8'hE2, 8'h41, 8'hF0, 8'h9F};
    send_stream();
    drain();
    // byte limit cutting an emoji in its middle
    write_limit(16'd2);
    stream_q = '{8'hF0, 8'h9F, 8'h9A, 8'h80};
    send_stream();

    // Random phases, each under its own byte limit and idling pattern
    random_bytes = 0;
    phase        = 0;
    while (random_bytes < RandomBytes) begin
      drain();
      in_gaps    = $urandom_range(3, 0) != 0;
      out_stalls = $urandom_range(3, 0) != 0;
      write_limit(phase_limit(phase));
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes && random_bytes + phase_bytes < RandomBytes) begin
        build_stream();
        send_stream();
        phase_bytes += stream_q.size();
      end
      random_bytes += phase_bytes;
      phase++;
    end
    drain();

    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
